>>> rtl/tild_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tild_pkg
// Shared types, character codes and helpers for the terminal input line
// discipline.
// ----------------------------------------------------------------------------
package tild_pkg;

   // Ring geometry; depth is a power of two so that pointers wrap by themselves
   localparam int RING_DEPTH = 512;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int PEND_W     = 9;
   localparam int LEN_W      = 16;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Input item kinds
   localparam logic [1:0] KIND_RX    = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // Configuration register indexes
   localparam logic CSR_CANONICAL = 1'b0;
   localparam logic CSR_ECHO      = 1'b1;

   // Character codes
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_FINAL_LO = 8'h40;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_TILDE    = 8'h7e;
   localparam logic [7:0] CH_DEL      = 8'h7f;

   typedef enum logic [1:0] {
      RK_ECHO  = 2'd0,
      RK_POP   = 2'd1,
      RK_EMPTY = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ESC_IDLE = 2'd0,
      ESC_SEEN = 2'd1,
      ESC_CSI  = 2'd2
   } esc_phase_type;

   // One accepted item's worth of results, handed from control to output
   typedef struct packed {
      result_kind_type   kind;
      logic [2:0][7:0]   echo;
      logic [1:0]        count;
      logic [PEND_W-1:0] pending;
   } job_type;

   function automatic logic [PEND_W-1:0] pend_sat(input logic [PTR_W-1:0] diff);
      logic [PEND_W-1:0] res;
      if (32'(diff) > 32'((1 << PEND_W) - 1)) begin
         res = '1;
      end else begin
         res = PEND_W'(diff);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tty_input_line_discipline.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tty_input_line_discipline
// Terminal receive line discipline with ring buffer, echo and escape tracking.
// ----------------------------------------------------------------------------
// Usage:
//  req_ carries one item per handshake: a received byte, a read request or
//  an input flush, selected by req_tuser. rsp_ returns echo bytes, popped
//  bytes or an empty indication, each with the ring fill after the item.
//  rsp_tlast marks the final result of an item; flushes and bytes that echo
//  nothing give no result. csr_ writes the canonical and echo mode bits.
//  The first result of an item is shown in the cycle after it is
//  accepted. Results leave one per cycle while rsp_tready is high, from a
//  single result register, one per echo byte for a received byte and one
//  for a read; the next item is accepted in the cycle the current item's
//  last result is taken, giving back to back items at one result a cycle.
//  A pop reads the ring memory at accept and the byte appears in the cycle after.
//  Reset clears pointers, line length and tracker and sets both mode bits;
//  the ring contents need no clearing. When rsp_tready is low the result
//  holds and req_tready drops until the last result is taken.
// ----------------------------------------------------------------------------
module tty_input_line_discipline
   import tild_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]  req_tuser,   // [1:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [16:8] pending_count
   output logic [1:0]       rsp_tuser,   // [1:0] result_kind
   output logic             rsp_tlast
);

   logic             accept;
   logic             free;
   logic             mem_we;
   logic [PTR_W-1:0] mem_waddr;
   logic [7:0]       mem_wdata;
   logic             mem_re;
   logic [PTR_W-1:0] mem_raddr;
   logic [7:0]       mem_rdata;
   logic             job_load;
   job_type          job;

   assign req_tready = free;
   assign accept     = req_tvalid && free;

   tild_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .item_kind (req_tuser),
      .item_byte (req_tdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .job_load  (job_load),
      .job       (job)
   );

   tild_ring u_ring (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tild_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (job_load),
      .job_in     (job),
      .ring_rdata (mem_rdata),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> rtl/tild_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tild_ring
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tild_ring
   import tild_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire logic [7:0]       wr_data,
   input  wire logic             rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output logic      [7:0]       rd_data
);

   logic [7:0] mem [RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last popped byte until the next pop
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/tild_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tild_ctrl
// Pointer, line length, escape tracker and mode state; decodes each item
// into ring accesses and a result job.
// ----------------------------------------------------------------------------
module tild_ctrl
   import tild_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic             csr_index,
   input  wire logic             csr_wdata,
   input  wire logic             accept,
   input  wire logic [1:0]       item_kind,
   input  wire logic [7:0]       item_byte,
   output logic                  mem_we,
   output logic [PTR_W-1:0]      mem_waddr,
   output logic [7:0]            mem_wdata,
   output logic                  mem_re,
   output logic [PTR_W-1:0]      mem_raddr,
   output logic                  job_load,
   output job_type               job
);

   logic             canon_ff, canon_in;
   logic             echo_ff, echo_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [LEN_W-1:0] len_ff, len_in;
   esc_phase_type    esc_ff, esc_in;

   logic [7:0]       chr;
   logic [PTR_W-1:0] wp_nxt;
   logic             active;
   logic             proc;
   logic             we;
   logic             re;
   logic             load;

   assign chr    = (item_byte == CH_CR) ? CH_LF : item_byte;
   assign wp_nxt = wp_ff + PTR_W'(1);
   assign active = canon_ff && echo_ff;

   always_comb begin
      canon_in = canon_ff;
      echo_in  = echo_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_CANONICAL: canon_in = csr_wdata;
            CSR_ECHO:      echo_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      len_in    = len_ff;
      esc_in    = esc_ff;
      we        = 1'b0;
      re        = 1'b0;
      load      = 1'b0;
      proc      = 1'b1;
      job       = '0;
      job.kind  = RK_ECHO;
      case (item_kind)
         KIND_RX: begin
            // drop the newest byte when the ring is full
            if (wp_nxt != rp_ff) begin
               we    = 1'b1;
               wp_in = wp_nxt;
            end
            if (!active) begin
               esc_in = ESC_IDLE;
            end else if (esc_ff == ESC_SEEN) begin
               if (chr == CH_LBRACKET) begin
                  esc_in = ESC_CSI;
                  proc   = 1'b0;
               end else begin
                  esc_in = ESC_IDLE;
               end
            end
            if (proc && active && esc_in == ESC_CSI) begin
               if (chr inside {[CH_FINAL_LO:CH_TILDE]}) begin
                  esc_in = ESC_IDLE;
               end
               proc = 1'b0;
            end
            if (proc && active && chr == CH_ESC) begin
               esc_in = ESC_SEEN;
               proc   = 1'b0;
            end
            if (proc && echo_ff) begin
               if (chr == CH_LF) begin
                  job.echo[0] = CH_CR;
                  job.echo[1] = CH_LF;
                  job.count   = 2'd2;
                  if (canon_ff) begin
                     len_in = '0;
                  end
               end else if (canon_ff && (chr == CH_BS || chr == CH_DEL)) begin
                  if (len_ff != '0) begin
                     len_in      = len_ff - LEN_W'(1);
                     job.echo[0] = CH_BS;
                     job.echo[1] = CH_SPACE;
                     job.echo[2] = CH_BS;
                     job.count   = 2'd3;
                  end
               end else if (chr inside {[CH_SPACE:CH_TILDE]}) begin
                  job.echo[0] = chr;
                  job.count   = 2'd1;
                  if (canon_ff && len_ff != LEN_MAX) begin
                     len_in = len_ff + LEN_W'(1);
                  end
               end
            end
            load = (job.count != 2'd0);
         end
         KIND_READ: begin
            if (rp_ff == wp_ff) begin
               job.kind = RK_EMPTY;
            end else begin
               re       = 1'b1;
               rp_in    = rp_ff + PTR_W'(1);
               job.kind = RK_POP;
            end
            job.count = 2'd1;
            load      = 1'b1;
         end
         KIND_FLUSH: begin
            wp_in  = '0;
            rp_in  = '0;
            len_in = '0;
            esc_in = ESC_IDLE;
         end
         default: ;
      endcase
      job.pending = pend_sat(wp_in - rp_in);
   end

   assign mem_we    = accept && we;
   assign mem_waddr = wp_ff;
   assign mem_wdata = chr;
   assign mem_re    = accept && re;
   assign mem_raddr = rp_ff;
   assign job_load  = accept && load;

   always_ff @(posedge clock) begin
      if (reset) begin
         canon_ff <= 1'b1;
         echo_ff  <= 1'b1;
         wp_ff    <= '0;
         rp_ff    <= '0;
         len_ff   <= '0;
         esc_ff   <= ESC_IDLE;
      end else begin
         canon_ff <= canon_in;
         echo_ff  <= echo_in;
         if (accept) begin
            wp_ff  <= wp_in;
            rp_ff  <= rp_in;
            len_ff <= len_in;
            esc_ff <= esc_in;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/tild_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tild_out
// Result register: holds one item's job and hands out its results one per
// cycle while rsp_tready is high, taking the popped byte from the ring read port.
// ----------------------------------------------------------------------------
module tild_out
   import tild_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire job_type     job_in,
   input  wire logic [7:0]  ring_rdata,
   output logic             free,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   job_type    job_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       take;
   logic [7:0] byte_out;

   assign last = (idx_ff == job_ff.count - 2'd1);
   assign take = valid_ff && rsp_tready;
   assign free = !valid_ff || (take && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (take) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_in;
      end
   end

   assign byte_out   = (job_ff.kind == RK_POP) ? ring_rdata : job_ff.echo[idx_ff];
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, job_ff.pending, byte_out};
   assign rsp_tuser  = job_ff.kind;
   assign rsp_tlast  = last;

endmodule
`default_nettype wire

>>> rtl/tild_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tild_chk
// Port-level checks for the terminal input line discipline.
// ----------------------------------------------------------------------------
module tild_chk
   import tild_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // an empty read is a lone result with a zero byte and an empty ring
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RK_EMPTY |-> rsp_tlast && rsp_tdata == 24'd0)
      else $error("bad empty-read result");

   // a pop is always the only result of its item
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == RK_POP |-> rsp_tlast)
      else $error("pop result not last");

   // no results straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // no new item while an earlier item still has results to come
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("item accepted mid-result");

endmodule

bind tty_input_line_discipline tild_chk u_chk (.*);
`default_nettype wire
